// ===== rtl/core/soft_knee_parallel_compressor_core_assert.svh =====
// soft_knee_parallel_compressor_core_assert.svh
// assertion macros for the compressor core; no dependencies
`ifndef SOFT_KNEE_PARALLEL_COMPRESSOR_CORE_ASSERT_SVH
`define SOFT_KNEE_PARALLEL_COMPRESSOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SKPC_ASSERT_IMP(label, ck, rn, pre, post, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
        else $error(msg);
`define SKPC_ASSERT_NXT(label, ck, rn, pre, post, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
        else $error(msg);
`else
`define SKPC_ASSERT_IMP(label, ck, rn, pre, post, msg)
`define SKPC_ASSERT_NXT(label, ck, rn, pre, post, msg)
`endif
`endif

// ===== rtl/core/skpc_pkg.sv =====
`timescale 1ns / 1ps
// skpc_pkg.sv
// shared types and constants of the compressor core; no dependencies

package skpc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;
    localparam int KNEE_W      = 13;
    localparam int MAKEUP_W    = 14;
    localparam int WET_W       = 17;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_THRESHOLD = 3'd0,
        REG_SLOPE     = 3'd1,
        REG_KNEE      = 3'd2,
        REG_ATTACK    = 3'd3,
        REG_RELEASE   = 3'd4,
        REG_MAKEUP    = 3'd5,
        REG_WET_MIX   = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic signed [15:0] threshold_db;
        logic [15:0]        slope;
        logic [KNEE_W-1:0]  knee_db;
        logic [15:0]        attack_coeff;
        logic [15:0]        release_coeff;
        logic [MAKEUP_W-1:0] makeup_db;
        logic [WET_W-1:0]   wet_mix;
    } cfg_t;

    localparam logic signed [15:0] THRESHOLD_RST = 16'shEC00;
    localparam logic [15:0]        SLOPE_RST     = 16'd57344;
    localparam logic [KNEE_W-1:0]  KNEE_RST      = 13'd1536;
    localparam logic [15:0]        ATTACK_RST    = 16'd66;
    localparam logic [15:0]        RELEASE_RST   = 16'd6554;
    localparam logic [MAKEUP_W-1:0] MAKEUP_RST   = 14'd3072;
    localparam logic [WET_W-1:0]   WET_RST       = 17'd32768;

    // 20*log10(2) and log2(10)/20 in Q16
    localparam logic signed [19:0] DB_PER_OCTAVE = 20'sd394566;
    localparam logic signed [14:0] GAIN_TO_LOG2  = 15'sd10885;
    localparam logic [15:0]        EXP_C0        = 16'd43024;
    localparam logic [14:0]        EXP_C1        = 15'd22512;
    localparam logic [16:0]        UNITY_Q16     = 17'd65536;
    localparam logic signed [15:0] LEVEL_FLOOR   = 16'sh9C00;

    localparam int LOG_STEPS  = 16;
    localparam int DIV_STEPS  = KNEE_W;
    localparam int STEP_CNT_W = 4;
    localparam int FIFO_DEPTH = 4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM,
        ST_LOG,
        ST_DB,
        ST_KNEE,
        ST_HARD,
        ST_SQ,
        ST_DIV,
        ST_GAIN,
        ST_EXP,
        ST_MANT,
        ST_WET,
        ST_SHIFT,
        ST_DRY,
        ST_MIX,
        ST_OUT
    } state_t;

endpackage

// ===== rtl/core/skpc_front.sv =====
`timescale 1ns / 1ps
// skpc_front.sv
// input side: takes samples, tracks the peak envelope, pushes work to the queue
// depends on skpc_pkg

module skpc_front
    import skpc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  cfg_t                           cfg,
    input  logic                           push,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    input  logic                           last_in,
    input  logic                           q_full,
    output logic                           q_push,
    output logic [2*SAMPLE_WIDTH:0]        q_data
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int MPW = SW + 16;

    logic [SW-1:0]  env_reg;
    logic [SW-1:0]  env_next;
    logic [SW-1:0]  mag;
    logic [SW-1:0]  diff;
    logic [SW-1:0]  step;
    logic [15:0]    coeff;
    logic [MPW-1:0] prod;
    logic           rising;

    always_comb
    begin
        mag      = sample_in[SW-1] ? (~sample_in + 1'b1) : sample_in;
        rising   = mag > env_reg;
        diff     = rising ? (mag - env_reg) : (env_reg - mag);
        coeff    = rising ? cfg.attack_coeff : cfg.release_coeff;
        prod     = MPW'(coeff) * MPW'(diff);
        step     = prod[MPW-1:16];
        env_next = rising ? (env_reg + step) : (env_reg - step);
        q_push   = push && !q_full;
        q_data   = {last_in, sample_in, env_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            env_reg <= '0;
        end
        else if (q_push)
        begin
            env_reg <= env_next;
        end
    end

endmodule

// ===== rtl/core/skpc_fifo.sv =====
`timescale 1ns / 1ps
// skpc_fifo.sv
// short register queue between the front and back sides
// depends on skpc_pkg

module skpc_fifo
    import skpc_pkg::*;
#(
    parameter int WIDTH = 33,
    parameter int DEPTH = FIFO_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [AW:0]      count_reg;
    logic [AW:0]      count_next;

    always_comb
    begin
        full        = count_reg == (AW+1)'(DEPTH);
        empty       = count_reg == '0;
        rd_data     = mem_reg[rd_ptr_reg];
        // depth is a power of two, pointers wrap on overflow
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/core/skpc_back.sv =====
`timescale 1ns / 1ps
// skpc_back.sv
// back side: log level, knee, makeup, exp gain, dry/wet mix, result register
// depends on skpc_pkg

module skpc_back
    import skpc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  cfg_t                           cfg,
    input  logic                           q_empty,
    input  logic [2*SAMPLE_WIDTH:0]        q_data,
    output logic                           q_pop,
    input  logic                           res_pop,
    output logic                           res_valid,
    output logic signed [SAMPLE_WIDTH-1:0] sample_out,
    output logic                           last_out
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int PBW  = $clog2(SW);
    localparam int PW   = PBW + 1;
    localparam int LGW  = PW + 16;
    localparam int LPW  = LGW + 20;
    localparam int LVW  = PW + 12;
    localparam int CW   = LVW + 3;
    localparam int P1W  = CW + 15;
    localparam int GRW  = CW - 1;
    localparam int GW   = CW + 1;
    localparam int EW   = GW + 15;
    localparam int NW   = EW - 24;
    localparam int RW   = SW + 17;
    localparam int MW   = SW + 10;
    localparam int WW   = SW + 11;
    localparam int DW   = SW + 18;
    localparam int XW   = SW + 29;
    localparam int OW   = XW - 16;
    localparam int YW   = KNEE_W + 1;
    localparam int YSW  = YW + 16;
    localparam int NPW  = YSW + YW;
    localparam int NUMW = NPW - 19;

    state_t                  state_reg, state_next;
    logic [STEP_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                    res_valid_reg, res_valid_next;
    logic signed [SW-1:0]    res_sample_reg, res_sample_next;
    logic                    res_last_reg, res_last_next;

    logic signed [SW-1:0]    s_reg, s_next;
    logic [SW-1:0]           mag_reg, mag_next;
    logic                    last_reg, last_next;
    logic [SW-1:0]           env_reg, env_next;
    logic [15:0]             m_reg, m_next;
    logic [PBW-1:0]          p_reg, p_next;
    logic [15:0]             frac_reg, frac_next;
    logic signed [LVW-1:0]   level_reg, level_next;
    logic [YW-1:0]           y_reg, y_next;
    logic [P1W-1:0]          prod1_reg, prod1_next;
    logic [KNEE_W-1:0]       rem_reg, rem_next;
    logic [KNEE_W-1:0]       dq_reg, dq_next;
    logic [GRW-1:0]          grmag_reg, grmag_next;
    logic signed [EW-1:0]    e_reg, e_next;
    logic [15:0]             t1_reg, t1_next;
    logic [16:0]             mant_reg, mant_next;
    logic [RW-1:0]           raw_reg, raw_next;
    logic signed [WW-1:0]    wet_reg, wet_next;
    logic signed [DW-1:0]    dry_reg, dry_next;
    logic signed [XW-1:0]    wp_reg, wp_next;

    logic [SW-1:0]           q_env;
    logic signed [SW-1:0]    q_s;
    logic [SW-1:0]           q_mag;
    logic                    q_last;
    logic [PBW-1:0]          lead;
    logic [SW-1:0]           envn;
    logic [SW+15:0]          envx;
    logic [31:0]             sq;
    logic [16:0]             sqt;
    logic signed [PW-1:0]    pm;
    logic signed [LPW-1:0]   lgx;
    logic signed [LPW-1:0]   lprod;
    logic signed [CW-1:0]    xs, ts, ks, x2, lo, hi, dd, yf;
    logic                    below, above;
    logic [CW-2:0]           mult_a;
    logic [NPW-1:0]          nprod;
    logic [NUMW-1:0]         num;
    logic [KNEE_W:0]         r2;
    logic                    ge;
    logic signed [GW-1:0]    g;
    logic signed [EW-1:0]    gx;
    logic [15:0]             f;
    logic [30:0]             c1prod;
    logic [31:0]             mprod;
    logic [NW:0]             rs;
    logic [RW-1:0]           shifted;
    logic [MW-1:0]           magw;
    logic [WET_W-1:0]        wv;
    logic [WET_W-1:0]        inv;
    logic signed [DW-1:0]    sx, ix;
    logic signed [XW-1:0]    wx, wmx, sumv;
    logic [OW-1:0]           mixv;
    logic                    fits;
    logic [SW-1:0]           satv;

    // datapath terms
    always_comb
    begin
        q_env  = q_data[SW-1:0];
        q_s    = q_data[2*SW-1:SW];
        q_last = q_data[2*SW];
        q_mag  = q_s[SW-1] ? (~q_s + 1'b1) : q_s;

        lead = '0;
        for (int i = 0; i < SW; i++)
        begin
            if (env_reg[i])
            begin
                lead = PBW'(i);
            end
        end
        envn = env_reg << (PBW'(SW - 1) - lead);
        envx = {envn, 16'd0};

        sq  = m_reg * m_reg;
        sqt = sq[31:15];

        pm    = $signed({1'b0, p_reg}) - PW'(SW - 1);
        lgx   = {{(LPW-LGW){pm[PW-1]}}, pm, frac_reg};
        lprod = lgx * LPW'(DB_PER_OCTAVE);

        xs     = {{(CW-LVW){level_reg[LVW-1]}}, level_reg};
        ts     = {{(CW-16){cfg.threshold_db[15]}}, cfg.threshold_db};
        ks     = {{(CW-KNEE_W){1'b0}}, cfg.knee_db};
        x2     = xs <<< 1;
        lo     = (ts <<< 1) - ks;
        hi     = (ts <<< 1) + ks;
        below  = x2 < lo;
        above  = x2 > hi;
        dd     = xs - ts;
        yf     = x2 - lo;
        mult_a = above ? dd[CW-2:0] : (CW-1)'(yf[YW-1:0]);

        nprod = NPW'(prod1_reg[YSW-1:0]) * NPW'(y_reg);
        num   = nprod[NPW-1:19];

        r2 = {rem_reg, dq_reg[KNEE_W-1]};
        ge = r2 >= {1'b0, cfg.knee_db};

        g  = $signed({{(GW-MAKEUP_W){1'b0}}, cfg.makeup_db})
             - $signed({{(GW-GRW){1'b0}}, grmag_reg});
        gx = {{(EW-GW){g[GW-1]}}, g};

        f      = e_reg[23:8];
        c1prod = 31'(EXP_C1) * 31'(f);
        mprod  = 32'(f) * 32'(t1_reg);

        rs = (NW+1)'(16) - {e_reg[EW-1], e_reg[EW-1:24]};
        if (rs[NW])
        begin
            shifted = raw_reg;
        end
        else if (rs[NW:6] != '0)
        begin
            shifted = '0;
        end
        else
        begin
            shifted = raw_reg >> rs[5:0];
        end
        magw = shifted[MW-1:0];

        wv  = (cfg.wet_mix > UNITY_Q16) ? UNITY_Q16 : cfg.wet_mix;
        inv = UNITY_Q16 - wv;
        sx  = {{(DW-SW){s_reg[SW-1]}}, s_reg};
        ix  = {{(DW-WET_W){1'b0}}, inv};
        wx  = {{(XW-WW){wet_reg[WW-1]}}, wet_reg};
        wmx = {{(XW-WET_W){1'b0}}, wv};

        sumv = wp_reg + {{(XW-DW){dry_reg[DW-1]}}, dry_reg};
        mixv = sumv[XW-1:16];
        fits = (mixv[OW-1:SW-1] == '0) || (mixv[OW-1:SW-1] == '1);
        satv = fits ? mixv[SW-1:0] : {mixv[OW-1], {(SW-1){~mixv[OW-1]}}};
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        res_valid_next  = res_valid_reg && !res_pop;
        res_sample_next = res_sample_reg;
        res_last_next   = res_last_reg;
        q_pop           = 1'b0;
        s_next          = s_reg;
        mag_next        = mag_reg;
        last_next       = last_reg;
        env_next        = env_reg;
        m_next          = m_reg;
        p_next          = p_reg;
        frac_next       = frac_reg;
        level_next      = level_reg;
        y_next          = y_reg;
        prod1_next      = prod1_reg;
        rem_next        = rem_reg;
        dq_next         = dq_reg;
        grmag_next      = grmag_reg;
        e_next          = e_reg;
        t1_next         = t1_reg;
        mant_next       = mant_reg;
        raw_next        = raw_reg;
        wet_next        = wet_reg;
        dry_next        = dry_reg;
        wp_next         = wp_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    s_next     = q_s;
                    mag_next   = q_mag;
                    last_next  = q_last;
                    env_next   = q_env;
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (env_reg == '0)
                begin
                    level_next = LVW'(LEVEL_FLOOR);
                    state_next = ST_KNEE;
                end
                else
                begin
                    p_next     = lead;
                    m_next     = envx[SW+15 -: 16];
                    frac_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_LOG;
                end
            end
            ST_LOG:
            begin
                m_next    = sqt[16] ? sqt[16:1] : sqt[15:0];
                frac_next = {frac_reg[14:0], sqt[16]};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == STEP_CNT_W'(LOG_STEPS - 1))
                begin
                    state_next = ST_DB;
                end
            end
            ST_DB:
            begin
                level_next = lprod[LPW-1:24];
                state_next = ST_KNEE;
            end
            ST_KNEE:
            begin
                prod1_next = P1W'(mult_a) * P1W'(cfg.slope);
                y_next     = yf[YW-1:0];
                if (below)
                begin
                    grmag_next = '0;
                    state_next = ST_GAIN;
                end
                else if (above)
                begin
                    state_next = ST_HARD;
                end
                else if (cfg.knee_db == '0)
                begin
                    grmag_next = '0;
                    state_next = ST_GAIN;
                end
                else
                begin
                    state_next = ST_SQ;
                end
            end
            ST_HARD:
            begin
                grmag_next = prod1_reg[P1W-1:16];
                state_next = ST_GAIN;
            end
            ST_SQ:
            begin
                rem_next   = KNEE_W'(num[NUMW-1:KNEE_W]);
                dq_next    = num[KNEE_W-1:0];
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = ge ? KNEE_W'(r2 - {1'b0, cfg.knee_db}) : r2[KNEE_W-1:0];
                dq_next  = {dq_reg[KNEE_W-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_CNT_W'(DIV_STEPS - 1))
                begin
                    grmag_next = GRW'({dq_reg[KNEE_W-2:0], ge});
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN:
            begin
                e_next     = gx * EW'(GAIN_TO_LOG2);
                state_next = ST_EXP;
            end
            ST_EXP:
            begin
                t1_next    = EXP_C0 + 16'(c1prod[30:16]);
                state_next = ST_MANT;
            end
            ST_MANT:
            begin
                mant_next  = UNITY_Q16 + 17'(mprod[31:16]);
                state_next = ST_WET;
            end
            ST_WET:
            begin
                raw_next   = RW'(mag_reg) * RW'(mant_reg);
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                wet_next   = s_reg[SW-1] ? -$signed({1'b0, magw}) : $signed({1'b0, magw});
                state_next = ST_DRY;
            end
            ST_DRY:
            begin
                dry_next   = sx * ix;
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                wp_next    = wx * wmx;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!res_valid_reg || res_pop)
                begin
                    res_valid_next  = 1'b1;
                    res_sample_next = satv;
                    res_last_next   = last_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_sample_reg <= res_sample_next;
        res_last_reg   <= res_last_next;
        s_reg          <= s_next;
        mag_reg        <= mag_next;
        last_reg       <= last_next;
        env_reg        <= env_next;
        m_reg          <= m_next;
        p_reg          <= p_next;
        frac_reg       <= frac_next;
        level_reg      <= level_next;
        y_reg          <= y_next;
        prod1_reg      <= prod1_next;
        rem_reg        <= rem_next;
        dq_reg         <= dq_next;
        grmag_reg      <= grmag_next;
        e_reg          <= e_next;
        t1_reg         <= t1_next;
        mant_reg       <= mant_next;
        raw_reg        <= raw_next;
        wet_reg        <= wet_next;
        dry_reg        <= dry_next;
        wp_reg         <= wp_next;
    end

    assign res_valid  = res_valid_reg;
    assign sample_out = res_sample_reg;
    assign last_out   = res_last_reg;

endmodule

// ===== rtl/core/soft_knee_parallel_compressor_core.sv =====
`timescale 1ns / 1ps
// soft_knee_parallel_compressor_core.sv
// top level: configuration registers, front side, queue, back side
// depends on skpc_pkg, skpc_front, skpc_fifo, skpc_back and the assertion header
`include "soft_knee_parallel_compressor_core_assert.svh"

// Soft-knee feed-forward compressor with dry/wet mix, one signed sample in and
// one saturated sample out. The input side updates the peak envelope and takes
// a sample every cycle until its 4-entry queue is full. The back end works on
// one sample at a time and holds the finished result in an output register, so
// it starts the next sample while a result waits to be popped. A zero envelope
// skips the log2 and uses the floor level. The 16-step squaring loop of the
// log2 runs for a nonzero envelope, the 13-step knee divider inside a soft
// knee. Sustained throughput is one sample per back end pass. Configuration
// must be written only while no sample is in flight; the block itself does
// not enforce this.

module soft_knee_parallel_compressor_core
    import skpc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [CFG_INDEX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    input  logic                           last_in,
    output logic                           empty,
    input  logic                           pop,
    output logic signed [SAMPLE_WIDTH-1:0] sample_out,
    output logic                           last_out
);

    localparam int QW = 2 * SAMPLE_WIDTH + 1;

    cfg_t          cfg_reg;
    cfg_t          cfg_next;
    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    logic [QW-1:0] q_wdata;
    logic [QW-1:0] q_rdata;
    logic          res_valid;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_THRESHOLD: cfg_next.threshold_db  = $signed(cfg_data[15:0]);
                REG_SLOPE:     cfg_next.slope         = cfg_data[15:0];
                REG_KNEE:      cfg_next.knee_db       = cfg_data[KNEE_W-1:0];
                REG_ATTACK:    cfg_next.attack_coeff  = cfg_data[15:0];
                REG_RELEASE:   cfg_next.release_coeff = cfg_data[15:0];
                REG_MAKEUP:    cfg_next.makeup_db     = cfg_data[MAKEUP_W-1:0];
                REG_WET_MIX:   cfg_next.wet_mix       = cfg_data[WET_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_db  <= THRESHOLD_RST;
            cfg_reg.slope         <= SLOPE_RST;
            cfg_reg.knee_db       <= KNEE_RST;
            cfg_reg.attack_coeff  <= ATTACK_RST;
            cfg_reg.release_coeff <= RELEASE_RST;
            cfg_reg.makeup_db     <= MAKEUP_RST;
            cfg_reg.wet_mix       <= WET_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    skpc_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .push      (push),
        .sample_in (sample_in),
        .last_in   (last_in),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    skpc_fifo #(
        .WIDTH (QW),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .full    (q_full),
        .empty   (q_empty)
    );

    skpc_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_empty    (q_empty),
        .q_data     (q_rdata),
        .q_pop      (q_pop),
        .res_pop    (pop),
        .res_valid  (res_valid),
        .sample_out (sample_out),
        .last_out   (last_out)
    );

    assign full  = q_full;
    assign empty = !res_valid;

    `SKPC_ASSERT_IMP(a_q_full_xor_empty, clk, rst_n, 1'b1, !(q_full && q_empty), "queue full and empty")
    `SKPC_ASSERT_IMP(a_pop_has_entry, clk, rst_n, q_pop, !q_empty, "back end read an empty queue")
    `SKPC_ASSERT_NXT(a_q_stays_empty, clk, rst_n, q_empty && !q_push, q_empty, "queue filled without a push")

endmodule
